// ===== rtl/assert_macros.svh =====
// assertion macros used by the drawing engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vfde_pkg.sv =====
// shared types, command codes and helpers of the voxel frame drawing engine
package vfde_pkg;

    localparam logic [3:0] K_SET       = 4'd0;
    localparam logic [3:0] K_CLEAR     = 4'd1;
    localparam logic [3:0] K_READ      = 4'd2;
    localparam logic [3:0] K_ALTER     = 4'd3;
    localparam logic [3:0] K_PLANE_SET = 4'd4;
    localparam logic [3:0] K_PLANE_CLR = 4'd5;
    localparam logic [3:0] K_FILL      = 4'd6;
    localparam logic [3:0] K_BOX       = 4'd7;
    localparam logic [3:0] K_WALLS     = 4'd8;
    localparam logic [3:0] K_WIRE      = 4'd9;
    localparam logic [3:0] K_LINE      = 4'd10;
    localparam logic [3:0] K_SHIFT     = 4'd11;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam int DIV_BITS = 7;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [2:0]          divisor;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } t_div_rsp;

    // rounded a/10 for 0 <= a < 155, by reciprocal multiply of a+5
    function automatic logic [3:0] round_tenth(input logic [7:0] a);
        logic [7:0]  s;
        logic [15:0] p;
        s = a + 8'd5;
        p = 16'(s) * 16'd205;
        return p[14:11];
    endfunction

endpackage

// ===== rtl/voxel_frame_drawing_engine.sv =====
// voxel frame drawing engine: command sequencer, row memory and line stepper
// sequencing: voxel commands pass S_RD, S_WR and S_FIN, unused kinds go straight to S_FIN,
// full-frame commands (plane, fill, boxes, shift) take an S_RD/S_WR pair for each row,
// line runs three divisions, then an S_RD/S_WR pair per point, t+1 points, t the longest axis delta
// throughput: one command at a time, the next request is taken once the result is offered
// reset: synchronous, clears per-row valid bits so the frame reads as all zeros
module voxel_frame_drawing_engine
    import vfde_pkg::*;
#(
    parameter int CUBE_EDGE = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_kind,
    input  logic [2:0] i_x_first,
    input  logic [2:0] i_y_first,
    input  logic [2:0] i_z_first,
    input  logic [2:0] i_x_second,
    input  logic [2:0] i_y_second,
    input  logic [2:0] i_z_second,
    input  logic [1:0] i_axis_sel,
    input  logic [2:0] i_plane_index,
    input  logic       i_shift_up,
    input  logic       i_draw_value,
    input  logic [7:0] i_fill_pattern,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_voxel_bit,
    output logic [3:0] o_done_kind
);

    `include "assert_macros.svh"

    localparam int ROWS = CUBE_EDGE * CUBE_EDGE;
    localparam int AW   = $clog2(ROWS);
    localparam int CW   = $clog2(CUBE_EDGE);
    localparam logic [CUBE_EDGE-1:0] MASK = '1;
    localparam logic [CUBE_EDGE-1:0] ONE  = CUBE_EDGE'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_WR   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    function automatic logic [2:0] clampc(input logic [2:0] v);
        return (int'(v) > CUBE_EDGE - 1) ? 3'(CUBE_EDGE - 1) : v;
    endfunction

    function automatic logic [AW-1:0] row_addr(input logic [CW-1:0] y, input logic [CW-1:0] z);
        return AW'(AW'(z) * AW'(CUBE_EDGE)) + AW'(y);
    endfunction

    function automatic logic [CUBE_EDGE-1:0] span(input logic [2:0] lo, input logic [2:0] hi);
        logic [CUBE_EDGE-1:0] a;
        logic [CUBE_EDGE-1:0] b;
        a = MASK << lo;
        b = MASK << ({1'b0, hi} + 4'd1);
        return a & ~b;
    endfunction

    function automatic logic [2:0] abs_d(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] d;
        d = {1'b0, b} - {1'b0, a};
        return d[3] ? 3'(4'd0 - d) : d[2:0];
    endfunction

    function automatic logic [6:0] times10(input logic [2:0] a);
        return 7'({a, 3'b000}) + 7'({a, 1'b0});
    endfunction

    t_state r_state;
    logic [3:0] r_kind;
    logic [2:0] r_xa, r_ya, r_za, r_xb, r_yb, r_zb;
    logic [1:0] r_axis;
    logic [2:0] r_plane;
    logic       r_up, r_val;
    logic [7:0] r_pat;
    logic       r_pass, r_line, r_final;
    logic [CW-1:0] r_ry, r_rz;
    logic [1:0] r_dax;
    logic       r_dwait;
    logic [6:0] r_magx, r_magy, r_magz;
    logic       r_negx, r_negy, r_negz;
    logic [7:0] r_qx, r_qy, r_qz;
    logic [7:0] r_ax, r_ay, r_az;
    logic [2:0] r_t, r_li;
    logic       r_bit;
    logic [CUBE_EDGE-1:0] r_mem [ROWS];
    logic [ROWS-1:0]      r_vld;
    logic [CUBE_EDGE-1:0] r_rdq;
    logic       r_rdok;
    logic       r_out_valid, r_out_bit;
    logic [3:0] r_out_kind;

    t_div_req div_req;
    t_div_rsp div_rsp;

    vfde_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // request capture
    logic       in_acc, is_box;
    logic [2:0] cxa, cya, cza, cxb, cyb, czb;
    logic [2:0] adx, ady, adz, tmax;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign is_box  = (i_kind == K_BOX) || (i_kind == K_WALLS) || (i_kind == K_WIRE);
    assign cxa = clampc(i_x_first);
    assign cya = clampc(i_y_first);
    assign cza = clampc(i_z_first);
    assign cxb = clampc(i_x_second);
    assign cyb = clampc(i_y_second);
    assign czb = clampc(i_z_second);
    assign adx = abs_d(i_x_first, i_x_second);
    assign ady = abs_d(i_y_first, i_y_second);
    assign adz = abs_d(i_z_first, i_z_second);

    always_comb begin
        tmax = adx;
        if (ady > tmax) tmax = ady;
        if (adz > tmax) tmax = adz;
    end

    // divider feed
    always_comb begin
        div_req.start    = (r_state == S_DIV) && !r_dwait && !div_rsp.busy;
        div_req.divisor  = r_t;
        case (r_dax)
            2'd0:    div_req.dividend = r_magx;
            2'd1:    div_req.dividend = r_magy;
            default: div_req.dividend = r_magz;
        endcase
    end

    logic [7:0] quot8, qsigned;
    logic       qneg;
    assign quot8 = 8'(div_rsp.quot);
    always_comb begin
        case (r_dax)
            2'd0:    qneg = r_negx;
            2'd1:    qneg = r_negy;
            default: qneg = r_negz;
        endcase
    end
    assign qsigned = qneg ? (8'd0 - quot8) : quot8;

    // current point for voxel and line commands
    logic [3:0] pt_x, pt_y, pt_z;
    logic       pin;
    always_comb begin
        if (r_line && !r_final) begin
            pt_x = round_tenth(r_ax);
            pt_y = round_tenth(r_ay);
            pt_z = round_tenth(r_az);
        end else if (r_line) begin
            pt_x = {1'b0, r_xb};
            pt_y = {1'b0, r_yb};
            pt_z = {1'b0, r_zb};
        end else begin
            pt_x = {1'b0, r_xa};
            pt_y = {1'b0, r_ya};
            pt_z = {1'b0, r_za};
        end
    end
    assign pin = (int'(pt_x) < CUBE_EDGE) && (int'(pt_y) < CUBE_EDGE) &&
                 (int'(pt_z) < CUBE_EDGE);

    // pass counters
    logic          desc, last_row;
    logic [CW-1:0] nxt_ry, nxt_rz;
    assign desc = (r_kind == K_SHIFT) && r_up;
    always_comb begin
        if (desc) begin
            last_row = (r_ry == '0) && (r_rz == '0);
            nxt_ry   = (r_ry == '0) ? CW'(CUBE_EDGE - 1) : r_ry - CW'(1);
            nxt_rz   = (r_ry == '0) ? r_rz - CW'(1) : r_rz;
        end else begin
            last_row = (r_ry == CW'(CUBE_EDGE - 1)) && (r_rz == CW'(CUBE_EDGE - 1));
            nxt_ry   = (r_ry == CW'(CUBE_EDGE - 1)) ? '0 : r_ry + CW'(1);
            nxt_rz   = (r_ry == CW'(CUBE_EDGE - 1)) ? r_rz + CW'(1) : r_rz;
        end
    end

    // addresses
    logic [AW-1:0] wa, ra;
    logic          sok;
    always_comb begin
        if (r_pass) wa = row_addr(r_ry, r_rz);
        else        wa = row_addr(CW'(pt_y), CW'(pt_z));
        ra  = wa;
        sok = 1'b1;
        if (r_pass && r_kind == K_SHIFT) begin
            if (r_axis == AX_Y) begin
                sok = r_up ? (r_ry != '0) : (r_ry != CW'(CUBE_EDGE - 1));
                if (sok) ra = row_addr(r_up ? r_ry - CW'(1) : r_ry + CW'(1), r_rz);
            end else if (r_axis == AX_Z) begin
                sok = r_up ? (r_rz != '0) : (r_rz != CW'(CUBE_EDGE - 1));
                if (sok) ra = row_addr(r_ry, r_up ? r_rz - CW'(1) : r_rz + CW'(1));
            end
        end
    end

    // row update
    logic [CUBE_EDGE-1:0] old_row, n_row, pbit, sp, ends, old_sh;
    logic yin, zin, yedge, zedge, we;
    assign old_row = r_rdok ? r_rdq : '0;
    assign old_sh  = old_row >> pt_x;
    assign pbit    = ONE << pt_x;
    assign sp      = span(r_xa, r_xb);
    assign ends    = (ONE << r_xa) | (ONE << r_xb);
    assign yin     = (int'(r_ry) >= int'(r_ya)) && (int'(r_ry) <= int'(r_yb));
    assign zin     = (int'(r_rz) >= int'(r_za)) && (int'(r_rz) <= int'(r_zb));
    assign yedge   = (int'(r_ry) == int'(r_ya)) || (int'(r_ry) == int'(r_yb));
    assign zedge   = (int'(r_rz) == int'(r_za)) || (int'(r_rz) == int'(r_zb));

    always_comb begin
        n_row = old_row;
        case (r_kind)
            K_SET:   n_row = old_row | pbit;
            K_CLEAR: n_row = old_row & ~pbit;
            K_ALTER, K_LINE: n_row = r_val ? (old_row | pbit) : (old_row & ~pbit);
            K_PLANE_SET, K_PLANE_CLR: begin
                if (int'(r_plane) < CUBE_EDGE) begin
                    if (r_axis == AX_X) begin
                        if (r_kind == K_PLANE_SET) n_row = old_row | (ONE << r_plane);
                        else                       n_row = old_row & ~(ONE << r_plane);
                    end else if ((r_axis == AX_Y && int'(r_ry) == int'(r_plane)) ||
                                 (r_axis == AX_Z && int'(r_rz) == int'(r_plane))) begin
                        n_row = (r_kind == K_PLANE_SET) ? MASK : '0;
                    end
                end
            end
            K_FILL:  n_row = CUBE_EDGE'(r_pat) & MASK;
            K_BOX:   if (yin && zin) n_row = old_row | sp;
            K_WALLS: begin
                if (yin && zin) n_row = (yedge || zedge) ? sp : (old_row | ends);
            end
            K_WIRE: begin
                if (yedge && zedge)                   n_row = sp;
                else if ((zedge && yin) || (yedge && zin)) n_row = old_row | ends;
            end
            K_SHIFT: begin
                // x shift moves bits inside the row, y and z shifts copy the neighbor row
                if (r_axis == AX_X) n_row = r_up ? (old_row << 1) : (old_row >> 1);
            end
            default: n_row = old_row;
        endcase
    end

    assign we = (r_state == S_WR) && (r_pass || (pin && r_kind != K_READ));

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= n_row;
        r_rdq <= r_mem[ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_dwait     <= 1'b0;
            r_pass      <= 1'b0;
            r_line      <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            if (we) r_vld[wa] <= 1'b1;
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind  <= i_kind;
                        r_xa    <= is_box ? ((cxa < cxb) ? cxa : cxb) : i_x_first;
                        r_xb    <= is_box ? ((cxa < cxb) ? cxb : cxa) : i_x_second;
                        r_ya    <= is_box ? ((cya < cyb) ? cya : cyb) : i_y_first;
                        r_yb    <= is_box ? ((cya < cyb) ? cyb : cya) : i_y_second;
                        r_za    <= is_box ? ((cza < czb) ? cza : czb) : i_z_first;
                        r_zb    <= is_box ? ((cza < czb) ? czb : cza) : i_z_second;
                        r_axis  <= i_axis_sel;
                        r_plane <= i_plane_index;
                        r_up    <= i_shift_up;
                        r_val   <= i_draw_value;
                        r_pat   <= i_fill_pattern;
                        r_bit   <= 1'b0;
                        r_final <= 1'b0;
                        r_pass  <= 1'b0;
                        r_line  <= 1'b0;
                        r_magx  <= times10(adx);
                        r_magy  <= times10(ady);
                        r_magz  <= times10(adz);
                        r_negx  <= i_x_second < i_x_first;
                        r_negy  <= i_y_second < i_y_first;
                        r_negz  <= i_z_second < i_z_first;
                        r_t     <= (tmax == 3'd0) ? 3'd1 : tmax;
                        r_dax   <= 2'd0;
                        r_li    <= 3'd0;
                        r_ry    <= (i_kind == K_SHIFT && i_shift_up) ? CW'(CUBE_EDGE - 1) : '0;
                        r_rz    <= (i_kind == K_SHIFT && i_shift_up) ? CW'(CUBE_EDGE - 1) : '0;
                        case (i_kind)
                            K_SET, K_CLEAR, K_READ, K_ALTER: r_state <= S_RD;
                            K_PLANE_SET, K_PLANE_CLR, K_FILL, K_BOX, K_WALLS, K_WIRE,
                            K_SHIFT: begin
                                r_pass  <= 1'b1;
                                r_state <= S_RD;
                            end
                            K_LINE: begin
                                r_line  <= 1'b1;
                                r_state <= S_DIV;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_req.start) r_dwait <= 1'b1;
                    if (div_rsp.done) begin
                        r_dwait <= 1'b0;
                        case (r_dax)
                            2'd0:    r_qx <= qsigned;
                            2'd1:    r_qy <= qsigned;
                            default: r_qz <= qsigned;
                        endcase
                        r_dax <= r_dax + 2'd1;
                        if (r_dax == 2'd2) begin
                            r_ax    <= 8'(times10(r_xa));
                            r_ay    <= 8'(times10(r_ya));
                            r_az    <= 8'(times10(r_za));
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_rdok  <= r_vld[ra] && sok;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_kind == K_READ) r_bit <= pin & old_sh[0];
                    if (r_pass) begin
                        if (last_row) begin
                            r_state <= S_FIN;
                        end else begin
                            r_ry    <= nxt_ry;
                            r_rz    <= nxt_rz;
                            r_state <= S_RD;
                        end
                    end else if (r_line && !r_final) begin
                        r_ax <= r_ax + r_qx;
                        r_ay <= r_ay + r_qy;
                        r_az <= r_az + r_qz;
                        r_li <= r_li + 3'd1;
                        if (r_li == r_t - 3'd1) r_final <= 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_bit   <= r_bit;
                        r_out_kind  <= r_kind;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_voxel_bit = r_out_bit;
    assign o_done_kind = r_out_kind;

    `VF_ASSERT_IMP(a_bit_only_on_read, i_clk, i_rst_n, o_valid && (o_done_kind != K_READ), !o_voxel_bit, "voxel bit set on a non-read result")
    `VF_ASSERT_NXT(a_busy_after_request, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "request accepted but block not busy")
    `VF_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy && (r_state == S_DIV), "divider started while busy")

endmodule

// ===== rtl/vfde_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module vfde_div
    import vfde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                r_busy;
    logic                r_done;
    logic [2:0]          r_cnt;
    logic [2:0]          r_rem;
    logic [DIV_BITS-1:0] r_quo;
    logic [3:0]          trial;

    assign trial = {r_rem, r_quo[DIV_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                if (trial >= {1'b0, i_req.divisor}) begin
                    r_rem <= 3'(trial - {1'b0, i_req.divisor});
                    r_quo <= {r_quo[DIV_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= trial[2:0];
                    r_quo <= {r_quo[DIV_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// ===== verif/voxel_frame_drawing_engine_tb.sv =====
// testbench of the voxel frame drawing engine: frame predictor, command stimulus, result check
module voxel_frame_drawing_engine_tb;
    import vfde_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE = 8;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [3:0] i_kind;
    logic [2:0] i_x_first, i_y_first, i_z_first;
    logic [2:0] i_x_second, i_y_second, i_z_second;
    logic [1:0] i_axis_sel;
    logic [2:0] i_plane_index;
    logic       i_shift_up;
    logic       i_draw_value;
    logic [7:0] i_fill_pattern;
    logic       o_valid;
    logic       i_stall;
    logic       o_voxel_bit;
    logic [3:0] o_done_kind;

    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] x1, y1, z1, x2, y2, z2;
        logic [1:0] axis;
        logic [2:0] plane;
        logic       up;
        logic       val;
        logic [7:0] pat;
    } t_cmd;

    typedef struct packed {
        logic       bit_v;
        logic [3:0] kind;
    } t_done;

    logic [7:0] frame_model [EDGE*EDGE];
    t_done      done_queue [$];
    int         mismatches;
    int         results_seen;
    int         requests_sent;
    int         cycle_count;
    bit         hold_off;
    bit         idle_recv;

    voxel_frame_drawing_engine u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // frame predictor helpers
    function automatic bit vox_get(int x, int y, int z);
        if (x < 0 || x >= EDGE || y < 0 || y >= EDGE || z < 0 || z >= EDGE) return 1'b0;
        return frame_model[z*EDGE + y][x];
    endfunction

    task automatic vox_put(int x, int y, int z, bit v);
        if (x < 0 || x >= EDGE || y < 0 || y >= EDGE || z < 0 || z >= EDGE) return;
        frame_model[z*EDGE + y][x] = v;
    endtask

    function automatic logic [7:0] span(int lo, int hi);
        logic [7:0] m;
        m = '0;
        for (int i = lo; i <= hi; i++) m[i] = 1'b1;
        return m;
    endfunction

    function automatic int tenth_round(int a);
        int q, r;
        q = a / 10;
        r = a - q * 10;
        if (r >= 5) q++;
        return q;
    endfunction

    task automatic apply_command(input t_cmd c, output t_done d);
        int x1, y1, z1, x2, y2, z2, t, a, b, cc, dx, dy, dz, tmp, dst, src;
        bit rd;
        x1 = int'(c.x1); y1 = int'(c.y1); z1 = int'(c.z1);
        x2 = int'(c.x2); y2 = int'(c.y2); z2 = int'(c.z2);
        rd = 1'b0;
        if (c.kind inside {K_BOX, K_WALLS, K_WIRE}) begin
            if (x1 > x2) begin tmp = x1; x1 = x2; x2 = tmp; end
            if (y1 > y2) begin tmp = y1; y1 = y2; y2 = tmp; end
            if (z1 > z2) begin tmp = z1; z1 = z2; z2 = tmp; end
        end
        case (c.kind)
            K_SET: vox_put(x1, y1, z1, 1'b1);
            K_CLEAR: vox_put(x1, y1, z1, 1'b0);
            K_READ: rd = vox_get(x1, y1, z1);
            K_ALTER: vox_put(x1, y1, z1, c.val);
            K_PLANE_SET, K_PLANE_CLR: begin
                if (c.axis <= AX_Z) begin
                    for (int z = 0; z < EDGE; z++)
                        for (int y = 0; y < EDGE; y++) begin
                            if (c.axis == AX_X)
                                frame_model[z*EDGE+y][c.plane] = (c.kind == K_PLANE_SET);
                            else if ((c.axis == AX_Y && y == int'(c.plane)) ||
                                     (c.axis == AX_Z && z == int'(c.plane)))
                                frame_model[z*EDGE+y] = (c.kind == K_PLANE_SET) ? 8'hff : 8'h00;
                        end
                end
            end
            K_FILL: for (int i = 0; i < EDGE*EDGE; i++) frame_model[i] = c.pat;
            K_BOX: begin
                for (int z = z1; z <= z2; z++)
                    for (int y = y1; y <= y2; y++)
                        frame_model[z*EDGE+y] |= span(x1, x2);
            end
            K_WALLS: begin
                for (int z = z1; z <= z2; z++)
                    for (int y = y1; y <= y2; y++) begin
                        if (y == y1 || y == y2 || z == z1 || z == z2)
                            frame_model[z*EDGE+y] = span(x1, x2);
                        else begin
                            frame_model[z*EDGE+y][x1] = 1'b1;
                            frame_model[z*EDGE+y][x2] = 1'b1;
                        end
                    end
            end
            K_WIRE: begin
                frame_model[z1*EDGE+y1] = span(x1, x2);
                frame_model[z1*EDGE+y2] = span(x1, x2);
                frame_model[z2*EDGE+y1] = span(x1, x2);
                frame_model[z2*EDGE+y2] = span(x1, x2);
                for (int y = y1; y <= y2; y++) begin
                    vox_put(x1, y, z1, 1'b1); vox_put(x1, y, z2, 1'b1);
                    vox_put(x2, y, z1, 1'b1); vox_put(x2, y, z2, 1'b1);
                end
                for (int z = z1; z <= z2; z++) begin
                    vox_put(x1, y1, z, 1'b1); vox_put(x1, y2, z, 1'b1);
                    vox_put(x2, y1, z, 1'b1); vox_put(x2, y2, z, 1'b1);
                end
            end
            K_LINE: begin
                dx = x2 - x1; dy = y2 - y1; dz = z2 - z1;
                t = (dx < 0) ? -dx : dx;
                if (((dy < 0) ? -dy : dy) > t) t = (dy < 0) ? -dy : dy;
                if (((dz < 0) ? -dz : dz) > t) t = (dz < 0) ? -dz : dz;
                if (t == 0) t = 1;
                a = x1 * 10; b = y1 * 10; cc = z1 * 10;
                dx = dx * 10 / t; dy = dy * 10 / t; dz = dz * 10 / t;
                for (int i = 0; i < t; i++) begin
                    vox_put(tenth_round(a), tenth_round(b), tenth_round(cc), c.val);
                    a += dx; b += dy; cc += dz;
                end
                vox_put(x2, y2, z2, c.val);
            end
            K_SHIFT: begin
                if (c.axis <= AX_Z) begin
                    for (int i = 0; i < EDGE; i++) begin
                        dst = c.up ? (EDGE - 1 - i) : i;
                        src = c.up ? dst - 1 : dst + 1;
                        for (int j = 0; j < EDGE; j++)
                            for (int k = 0; k < EDGE; k++) begin
                                if (c.axis == AX_Z)
                                    vox_put(j, k, dst, vox_get(j, k, src));
                                else if (c.axis == AX_Y)
                                    vox_put(j, dst, k, vox_get(j, src, k));
                                else
                                    vox_put(dst, k, j, vox_get(src, k, j));
                            end
                    end
                end
            end
            default: ;
        endcase
        d.bit_v = rd;
        d.kind = c.kind;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, want);
    endtask

    // send one request, predicting it when accepted
    task automatic send_cmd(input t_cmd c, input bit no_gap = 1'b0);
        t_done d;
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= c.kind;
        i_x_first      <= c.x1;
        i_y_first      <= c.y1;
        i_z_first      <= c.z1;
        i_x_second     <= c.x2;
        i_y_second     <= c.y2;
        i_z_second     <= c.z2;
        i_axis_sel     <= c.axis;
        i_plane_index  <= c.plane;
        i_shift_up     <= c.up;
        i_draw_value   <= c.val;
        i_fill_pattern <= c.pat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_command(c, d);
        done_queue.push_back(d);
        requests_sent++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (done_queue.size() == 0) begin
                report_mismatch("unexpected result kind", int'(o_done_kind), -1);
            end else begin
                t_done w;
                w = done_queue.pop_front();
                if (o_done_kind !== w.kind)
                    report_mismatch("done_kind", int'(o_done_kind), int'(w.kind));
                if (o_voxel_bit !== w.bit_v)
                    report_mismatch("voxel_bit", int'(o_voxel_bit), int'(w.bit_v));
            end
        end
    end

    // receiver stall: random per result, long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_off = 1'b0;
            end else if (!idle_recv && o_valid && !i_stall) begin
                int w;
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                if (w > 0) begin
                    i_stall <= 1'b1;
                    repeat (w) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    function automatic t_cmd rand_cmd(input logic [3:0] kind);
        t_cmd c;
        logic [63:0] r;
        r = {$urandom, $urandom};
        c = r[$bits(t_cmd)-1:0];
        c.kind = kind;
        return c;
    endfunction

    function automatic t_cmd voxel_cmd(logic [3:0] k, int x, int y, int z, bit v);
        t_cmd c;
        c = '0;
        c.kind = k; c.x1 = 3'(x); c.y1 = 3'(y); c.z1 = 3'(z); c.val = v;
        return c;
    endfunction

    task automatic test_directed();
        t_cmd c;
        send_cmd(voxel_cmd(K_READ, 7, 7, 7, 0));
        send_cmd(voxel_cmd(K_SET, 0, 0, 0, 0));
        send_cmd(voxel_cmd(K_SET, 7, 7, 7, 0));
        send_cmd(voxel_cmd(K_READ, 7, 7, 7, 0));
        send_cmd(voxel_cmd(K_ALTER, 3, 4, 5, 1));
        send_cmd(voxel_cmd(K_READ, 3, 4, 5, 0));
        send_cmd(voxel_cmd(K_CLEAR, 7, 7, 7, 0));
        send_cmd(voxel_cmd(K_READ, 7, 7, 7, 0));
        c = rand_cmd(K_FILL); c.pat = 8'hff; send_cmd(c);
        c = rand_cmd(K_FILL); c.pat = 8'h00; send_cmd(c);
        c = rand_cmd(K_PLANE_SET); c.axis = AX_X; c.plane = 3'd7; send_cmd(c);
        c = rand_cmd(K_PLANE_SET); c.axis = AX_Z; c.plane = 3'd0; send_cmd(c);
        c = rand_cmd(K_PLANE_CLR); c.axis = AX_Y; c.plane = 3'd0; send_cmd(c);
        c = rand_cmd(K_PLANE_SET); c.axis = 2'd3; send_cmd(c);
        c = rand_cmd(K_SHIFT); c.axis = AX_Z; c.up = 1'b1; send_cmd(c);
        c = rand_cmd(K_SHIFT); c.axis = AX_X; c.up = 1'b0; send_cmd(c);
        c = rand_cmd(K_SHIFT); c.axis = 2'd3; send_cmd(c);
        c = '0; c.kind = K_BOX; c.x1 = 3'd7; c.y1 = 3'd6; c.z1 = 3'd5; send_cmd(c);
        c = '0; c.kind = K_WALLS; c.x1 = 3'd1; c.x2 = 3'd6; c.y2 = 3'd7; c.z1 = 3'd7;
        send_cmd(c);
        c = '0; c.kind = K_WIRE; c.x1 = 3'd6; c.x2 = 3'd1; c.y1 = 3'd2; c.y2 = 3'd5;
        c.z2 = 3'd7; send_cmd(c);
        c = '0; c.kind = K_LINE; c.x2 = 3'd7; c.y2 = 3'd3; c.z2 = 3'd7; c.val = 1'b1;
        send_cmd(c);
        c = '0; c.kind = K_LINE; c.x1 = 3'd7; c.y1 = 3'd7; c.z1 = 3'd7; c.val = 1'b1;
        send_cmd(c);
        c = '0; c.kind = K_LINE; c.x1 = 3'd2; c.x2 = 3'd2; c.val = 1'b0; send_cmd(c);
        for (int k = 12; k < 16; k++) send_cmd(rand_cmd(4'(k)));
    endtask

    task automatic test_random(int n);
        t_cmd c;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            // mostly voxel and line traffic, with some full-frame and odd kinds
            if (r < 45) c = rand_cmd(4'($urandom_range(0, 3)));
            else if (r < 60) c = rand_cmd(K_LINE);
            else if (r < 95) c = rand_cmd(4'($urandom_range(4, 11)));
            else c = rand_cmd(4'($urandom_range(12, 15)));
            if (c.kind == K_FILL && $urandom_range(0, 1)) c.pat = 8'h00;
            send_cmd(c);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 40; i++) send_cmd(rand_cmd(4'($urandom_range(0, 3))), 1'b1);
    endtask

    task automatic test_streaming();
        idle_recv = 1'b1;
        for (int i = 0; i < 60; i++) send_cmd(rand_cmd(4'($urandom_range(0, 11))), 1'b1);
        idle_recv = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_kind = '0;
        i_x_first = '0; i_y_first = '0; i_z_first = '0;
        i_x_second = '0; i_y_second = '0; i_z_second = '0;
        i_axis_sel = '0; i_plane_index = '0; i_shift_up = 1'b0;
        i_draw_value = 1'b0; i_fill_pattern = '0;
        mismatches = 0; results_seen = 0; requests_sent = 0;
        hold_off = 1'b0; idle_recv = 1'b0;
        for (int i = 0; i < EDGE*EDGE; i++) frame_model[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_streaming();
        test_random(1600);
        i_valid <= 1'b0;
        while (done_queue.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("ran %0d drawing requests, checked %0d results", requests_sent, results_seen);
        $display("covered voxel, plane, fill, box, line, shift and unused kinds with stalls");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/vfde_pkg.sv
rtl/vfde_div.sv
rtl/voxel_frame_drawing_engine.sv
verif/voxel_frame_drawing_engine_tb.sv
